@@ rtl/itbd_pkg.sv @@
package itbd_pkg;

	localparam int VALUE_W     = 32;
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int CNT_W       = $clog2(VALUE_W + 1);
	localparam int ADDR_W      = $clog2(VALUE_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [DIGIT_W-1:0] FIRST_LETTER_DIGIT = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  CHAR_A      = CHAR_W'(97);
	localparam logic [CHAR_W-1:0]  CHAR_MINUS  = CHAR_W'(45);

	localparam logic CFG_RADIX       = 1'b0;
	localparam logic CFG_SIGNED_MODE = 1'b1;

	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic               neg;
		logic [RADIX_W-1:0] radix;
		logic [VALUE_W-1:0] recip;
	} job_t;

	// floor(2^32 / radix): the quotient estimate is exact or one short
	function automatic logic [VALUE_W-1:0] recip_of(input logic [RADIX_W-1:0] r);
		logic [VALUE_W-1:0] m;
		case (r)
			6'd2:    m = 32'd2147483648;
			6'd3:    m = 32'd1431655765;
			6'd4:    m = 32'd1073741824;
			6'd5:    m = 32'd858993459;
			6'd6:    m = 32'd715827882;
			6'd7:    m = 32'd613566756;
			6'd8:    m = 32'd536870912;
			6'd9:    m = 32'd477218588;
			6'd10:   m = 32'd429496729;
			6'd11:   m = 32'd390451572;
			6'd12:   m = 32'd357913941;
			6'd13:   m = 32'd330382099;
			6'd14:   m = 32'd306783378;
			6'd15:   m = 32'd286331153;
			6'd16:   m = 32'd268435456;
			6'd17:   m = 32'd252645135;
			6'd18:   m = 32'd238609294;
			6'd19:   m = 32'd226050910;
			6'd20:   m = 32'd214748364;
			6'd21:   m = 32'd204522252;
			6'd22:   m = 32'd195225786;
			6'd23:   m = 32'd186737708;
			6'd24:   m = 32'd178956970;
			6'd25:   m = 32'd171798691;
			6'd26:   m = 32'd165191049;
			6'd27:   m = 32'd159072862;
			6'd28:   m = 32'd153391689;
			6'd29:   m = 32'd148102320;
			6'd30:   m = 32'd143165576;
			6'd31:   m = 32'd138547332;
			6'd32:   m = 32'd134217728;
			6'd33:   m = 32'd130150524;
			6'd34:   m = 32'd126322567;
			6'd35:   m = 32'd122713351;
			6'd36:   m = 32'd119304647;
			default: m = 32'd429496729;
		endcase
		return m;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < FIRST_LETTER_DIGIT) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - FIRST_LETTER_DIGIT);
		end
		return c;
	endfunction

endpackage

@@ rtl/itbd_front.sv @@
module itbd_front import itbd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [RADIX_W-1:0] cfg_data,
	input  logic               value_valid,
	output logic               value_stall,
	input  logic [VALUE_W-1:0] value,
	input  logic               queue_full,
	output logic               push,
	output job_t               job
);

	logic [RADIX_W-1:0] radix_q;
	logic               signed_mode_q;
	logic [RADIX_W-1:0] radix_eff;
	logic               neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RESET;
			signed_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIX:       radix_q       <= cfg_data;
				CFG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default:         radix_q       <= radix_q;
			endcase
		end
	end

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			radix_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			radix_eff = RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	assign neg         = signed_mode_q & value[VALUE_W-1];
	assign value_stall = queue_full;
	assign push        = value_valid & ~queue_full;

	assign job.mag   = neg ? (~value + VALUE_W'(1)) : value;
	assign job.neg   = neg;
	assign job.radix = radix_eff;
	assign job.recip = recip_of(radix_eff);

endmodule

@@ rtl/itbd_queue.sv @@
module itbd_queue import itbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/itbd_back.sv @@
module itbd_back import itbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  job_t              job,
	input  logic              queue_empty,
	output logic              pop,
	output logic              char_valid,
	input  logic              char_stall,
	output logic [CHAR_W-1:0] char_code,
	output logic              last
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_FIX  = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] quot_q;
	logic               neg_q;
	logic [RADIX_W-1:0] radix_q;
	logic [VALUE_W-1:0] recip_q;
	logic [VALUE_W-1:0] prod_hi_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               buf_valid_q;
	logic               buf_last_q;
	logic [DIGIT_W-1:0] rd_data_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	logic [DIGIT_W-1:0] digit_mem [VALUE_W];

	logic [2*VALUE_W-1:0] prod;
	logic [CHAR_W-1:0]    qr_low;
	logic [CHAR_W-1:0]    rem_est;
	logic                 fix_up;
	logic [VALUE_W-1:0]   quot_next;
	logic [DIGIT_W-1:0]   digit;
	logic                 div_done;
	logic                 out_free;
	logic                 rd_en;
	logic                 sign_push;
	logic                 emit_done;

	assign prod      = quot_q * recip_q;
	assign qr_low    = CHAR_W'(prod_hi_q[CHAR_W-1:0] * radix_q);
	assign rem_est   = quot_q[CHAR_W-1:0] - qr_low;
	assign fix_up    = (rem_est >= CHAR_W'(radix_q));
	assign quot_next = prod_hi_q + VALUE_W'(fix_up);
	assign digit     = DIGIT_W'(fix_up ? (rem_est - CHAR_W'(radix_q)) : rem_est);
	assign div_done  = (quot_next == '0) || (cnt_q == CNT_W'(VALUE_W - 1));

	assign pop       = (state_q == ST_IDLE) && !queue_empty;
	assign out_free  = !out_valid_q || !char_stall;
	assign rd_en     = (state_q == ST_EMIT) && (rd_cnt_q != '0) && (!buf_valid_q || out_free);
	assign sign_push = (state_q == ST_SIGN) && out_free;
	assign emit_done = (rd_cnt_q == '0) && (!buf_valid_q || out_free);

	assign char_valid = out_valid_q;
	assign char_code  = out_char_q;
	assign last       = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			quot_q   <= '0;
			cnt_q    <= '0;
			rd_cnt_q <= '0;
			neg_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						quot_q  <= job.mag;
						neg_q   <= job.neg;
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					quot_q <= quot_next;
					cnt_q  <= cnt_q + CNT_W'(1);
					if (div_done) begin
						rd_cnt_q <= cnt_q + CNT_W'(1);
						state_q  <= neg_q ? ST_SIGN : ST_EMIT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_SIGN: begin
					if (sign_push) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q - CNT_W'(1);
					end
					if (emit_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// job fields and product, no reset needed
	always_ff @(posedge clk) begin
		if (pop) begin
			radix_q <= job.radix;
			recip_q <= job.recip;
		end
		if (state_q == ST_MUL) begin
			prod_hi_q <= prod[2*VALUE_W-1:VALUE_W];
		end
	end

	// digit store, least significant digit at address zero
	always_ff @(posedge clk) begin
		if (state_q == ST_FIX) begin
			digit_mem[cnt_q[ADDR_W-1:0]] <= digit;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= digit_mem[rd_cnt_q[ADDR_W-1:0] - ADDR_W'(1)];
			buf_last_q <= (rd_cnt_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
		end else if (rd_en) begin
			buf_valid_q <= 1'b1;
		end else if (buf_valid_q && out_free) begin
			buf_valid_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= buf_valid_q || sign_push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (buf_valid_q) begin
				out_char_q <= digit_char(rd_data_q);
				out_last_q <= buf_last_q;
			end else if (sign_push) begin
				out_char_q <= CHAR_MINUS;
				out_last_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/integer_to_base_digits.sv @@
// channel   payload              handshake
// value     value[31:0]          value_valid / value_stall
// char      char_code[6:0], last char_valid / char_stall
// cfg       cfg_index, cfg_data  cfg_we
//
// each digit passes through the back part as a 32x32 reciprocal multiply, then a
// correction step that writes the digit store; characters then leave one per cycle
// while char_stall is low
// the front part and a two-entry queue take new values while the back part works
// arst_n clears control state and sets radix 10, unsigned
// char_stall holds the output register; the digit store read waits behind it
module integer_to_base_digits import itbd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [RADIX_W-1:0] cfg_data,
	input  logic               value_valid,
	output logic               value_stall,
	input  logic [VALUE_W-1:0] value,
	output logic               char_valid,
	input  logic               char_stall,
	output logic [CHAR_W-1:0]  char_code,
	output logic               last
);

	job_t push_job;
	job_t pop_job;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;

	itbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.queue_full  (queue_full),
		.push        (push),
		.job         (push_job)
	);

	itbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (queue_empty)
	);

	itbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (pop_job),
		.queue_empty (queue_empty),
		.pop         (pop),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.last        (last)
	);

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

import itbd_pkg::*;

class radix_text_board;
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_t;

	logic [RADIX_W-1:0] radix;
	logic               signed_mode;
	char_t              pending_chars[$];
	int                 errors;
	int                 numbers;
	int                 chars_seen;

	function new();
		radix       = RADIX_RESET;
		signed_mode = 1'b0;
		errors      = 0;
		numbers     = 0;
		chars_seen  = 0;
	endfunction

	function void add_expected(input char_t c);
		pending_chars.insert(pending_chars.size(), c);
	endfunction

	// expected characters of one accepted value, most significant first
	function void spell_number(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		logic [RADIX_W-1:0] base;
		logic [DIGIT_W-1:0] digits[$];
		char_t              c;
		int                 i;
		base = radix;
		if (radix < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			base = RADIX_MAX;
		end
		mag = v;
		numbers++;
		if (signed_mode && v[VALUE_W-1]) begin
			mag = '0 - v;
			c.code = CHAR_MINUS;
			c.last = 1'b0;
			add_expected(c);
		end
		do begin
			digits.push_front(DIGIT_W'(mag % VALUE_W'(base)));
			mag = mag / VALUE_W'(base);
		end while (mag != '0);
		for (i = 0; i < digits.size(); i++) begin
			if (digits[i] < FIRST_LETTER_DIGIT) begin
				c.code = CHAR_ZERO + CHAR_W'(digits[i]);
			end else begin
				c.code = CHAR_A + CHAR_W'(digits[i] - FIRST_LETTER_DIGIT);
			end
			c.last = (i == digits.size() - 1);
			add_expected(c);
		end
	endfunction

	function void check_char(input logic [CHAR_W-1:0] code, input logic lst);
		char_t exp_c;
		chars_seen++;
		if (pending_chars.size() == 0) begin
			$display("%0t: unexpected char: expected none, actual code 0x%0h last %0b",
				$time, code, lst);
			errors++;
		end else begin
			exp_c = pending_chars.pop_front();
			if (code !== exp_c.code) begin
				$display("%0t: char_code mismatch: expected 0x%0h, actual 0x%0h",
					$time, exp_c.code, code);
				errors++;
			end
			if (lst !== exp_c.last) begin
				$display("%0t: last mismatch: expected %0b, actual %0b",
					$time, exp_c.last, lst);
				errors++;
			end
		end
	endfunction
endclass

module tb_top;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [RADIX_W-1:0] cfg_data;
	logic               value_valid;
	logic               value_stall;
	logic [VALUE_W-1:0] value;
	logic               char_valid;
	logic               char_stall;
	logic [CHAR_W-1:0]  char_code;
	logic               last;

	radix_text_board text_check;
	bit              quiet;
	int              settings_used;

	integer_to_base_digits dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.value      (value),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	// character side: sample at the falling edge, accept at the next rising edge
	initial begin
		logic              cv;
		logic              cs;
		logic [CHAR_W-1:0] cc;
		logic              cl;
		char_stall <= 1'b0;
		forever begin
			@(negedge clk);
			cv = char_valid;
			cs = char_stall;
			cc = char_code;
			cl = last;
			@(posedge clk);
			if (cv && !cs) begin
				text_check.check_char(cc, cl);
			end
			if (!arst_n || quiet) begin
				char_stall <= 1'b0;
			end else begin
				char_stall <= ($urandom_range(99) < 34);
			end
		end
	end

	task automatic apply_mode(input logic [RADIX_W-1:0] r, input logic s);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_RADIX;
		cfg_data  <= r;
		@(posedge clk);
		cfg_index <= CFG_SIGNED_MODE;
		cfg_data  <= RADIX_W'(s);
		@(posedge clk);
		cfg_we <= 1'b0;
		text_check.radix       = r;
		text_check.signed_mode = s;
		settings_used++;
	endtask

	task automatic send_number(input logic [VALUE_W-1:0] v);
		logic stalled;
		if (!quiet && $urandom_range(99) < 34) begin
			value_valid <= 1'b0;
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(20, 120)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		value_valid <= 1'b1;
		value       <= v;
		forever begin
			@(negedge clk);
			stalled = value_stall;
			@(posedge clk);
			if (!stalled) begin
				break;
			end
		end
		text_check.spell_number(v);
	endtask

	task automatic wait_drained(input int settle);
		value_valid <= 1'b0;
		while (text_check.pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(11))
			0:       v = '0;
			1:       v = '1;
			2:       v = {1'b1, {(VALUE_W-1){1'b0}}};
			3:       v = {1'b0, {(VALUE_W-1){1'b1}}};
			4:       v = VALUE_W'($urandom_range(40));
			default: v = $urandom >> $urandom_range(31);
		endcase
		return v;
	endfunction

	initial begin
		logic [RADIX_W-1:0] r;
		int                 p;
		int                 n;
		int                 count;
		text_check    = new();
		settings_used = 1;
		quiet         = 1'b0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_RADIX;
		cfg_data      <= '0;
		value_valid   <= 1'b0;
		value         <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: decimal, unsigned
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'd9);
		send_number(32'd10);
		send_number(32'hFFFF_FFFF);
		send_number(32'h8000_0000);
		wait_drained(110);

		// binary signed: longest output is the most negative value
		apply_mode(6'd2, 1'b1);
		send_number(32'h8000_0000);
		send_number(32'hFFFF_FFFF);
		send_number(32'h7FFF_FFFF);
		send_number(32'd0);
		send_number(32'd1);
		wait_drained(110);

		apply_mode(6'd36, 1'b0);
		send_number(32'd35);
		send_number(32'd36);
		send_number(32'hFFFF_FFFF);
		send_number(32'd0);
		wait_drained(110);

		// bases outside 2..36 saturate
		apply_mode(6'd0, 1'b0);
		send_number(32'd5);
		wait_drained(110);
		apply_mode(6'd1, 1'b0);
		send_number(32'd6);
		wait_drained(110);
		apply_mode(6'd37, 1'b0);
		send_number(32'd1295);
		wait_drained(110);
		apply_mode(6'd63, 1'b1);
		send_number(32'hFFFF_FFFF);
		wait_drained(110);

		apply_mode(6'd16, 1'b1);
		send_number(32'hFFFF_FFFF);
		send_number(32'h8000_0000);
		wait_drained(110);

		count = 0;
		for (p = 0; p < 10; p++) begin
			case ($urandom_range(9))
				0:       r = RADIX_W'($urandom_range(1));
				1:       r = RADIX_W'($urandom_range(37, 63));
				2:       r = RADIX_MAX;
				3:       r = RADIX_MIN;
				default: r = RADIX_W'($urandom_range(2, 36));
			endcase
			apply_mode(r, 1'($urandom_range(1)));
			quiet = (p == 5);
			for (n = 0; n < 24; n++) begin
				send_number(pick_value());
				count++;
				if (p == 3 && n == 12) begin
					wait_drained(0);
				end
			end
			wait_drained(110);
		end
		quiet = 1'b0;

		$display("sent %0d numbers (%0d random) under %0d radix and sign settings",
			text_check.numbers, count, settings_used);
		$display("checked %0d characters", text_check.chars_seen);
		if (text_check.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
